FILE: sv/twf_pkg.sv
// twf_pkg: shared types and constants of the three-voice wavetable fetcher
// no dependencies; imported by every module and by nothing else
package twf_pkg;

	// default sample memory address width, memory depth is 2**width (8 to 16)
	localparam int SAMPLE_ADDR_W_DEF = 12;
	// default cycles per phase tick (1 to 256)
	localparam int TICK_DIVIDER_DEF = 60;

	localparam int NUM_VOICES = 3;

	// reset value of every voice size shift
	localparam logic [4:0] SIZE_SHIFT_RST = 5'd27;

	// write pointer masks for the two pointer widths
	localparam logic [15:0] PTR_MASK_PLUS = 16'hFFFF;
	localparam logic [15:0] PTR_MASK_STD  = 16'h0FFF;

	// packed-sample address shift and nibble select bit
	localparam logic [4:0] DIG_SHIFT_PLUS = 5'd13;
	localparam logic [4:0] DIG_SHIFT_STD  = 5'd21;
	localparam logic [4:0] NIB_BIT_PLUS   = 5'd12;
	localparam logic [4:0] NIB_BIT_STD    = 5'd20;

	// host commands
	typedef enum logic [2:0] {
		CMD_SET_NOTE   = 3'd0,
		CMD_RESET_CNT  = 3'd1,
		CMD_READ_CNT   = 3'd2,
		CMD_SET_SIZE   = 3'd3,
		CMD_PTR_BYTE   = 3'd4,
		CMD_WRITE_BYTE = 3'd5,
		CMD_SET_MODE   = 3'd6,
		CMD_MUSIC_READ = 3'd7
	} cmd_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_PLUS   = 2'd0,
		REG_BASE_A = 2'd1,
		REG_BASE_B = 2'd2,
		REG_BASE_C = 2'd3
	} reg_idx_t;

	// music read sequencer
	typedef enum logic [2:0] {
		MS_IDLE,
		MS_QUOT,
		MS_REM,
		MS_FIX,
		MS_ADV,
		MS_READ,
		MS_SUM
	} ms_state_t;

endpackage

FILE: sv/twf_if.sv
// twf_req_if and twf_rsp_if: valid/ready channels of the wavetable fetcher
// no dependencies
interface twf_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [1:0]  voice;
	logic [31:0] value;
	logic [31:0] cycle_now;

	modport source (output valid, cmd, voice, value, cycle_now, input ready);
	modport sink (input valid, cmd, voice, value, cycle_now, output ready);
endinterface

interface twf_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_value;

	modport source (output valid, result_value, input ready);
	modport sink (input valid, result_value, output ready);
endinterface

FILE: sv/twf_sample_ram.sv
// twf_sample_ram: byte-wide sample memory, one write and one registered read port,
// with a clearing sweep after reset; depends on twf_pkg
module twf_sample_ram
	import twf_pkg::*;
#(
	parameter int ADDR_W = SAMPLE_ADDR_W_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data,
	output logic              clearing
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [7:0]        mem [DEPTH];
	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;

	assign clearing = clr_q;

	// clearing sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (&clr_addr_q) begin
				clr_q <= 1'b0;
			end
		end
	end

	// sweep owns the write port while it runs
	assign we    = clr_q | wr_en;
	assign waddr = clr_q ? clr_addr_q : wr_addr;
	assign wdata = clr_q ? 8'd0 : wr_data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/three_voice_wavetable_fetcher_top.sv
// three_voice_wavetable_fetcher_top: host command front end of a three-voice
// wavetable fetcher; depends on twf_pkg, twf_if and twf_sample_ram.
// The host sends words on req (cmd, voice, value, cycle_now); every word yields
// exactly one word on rsp (result_value), in order. An APB port holds the
// variant bit and the three table bases; write it only while the block is idle.
// Commands other than music read stream at one word a cycle while rsp is taken.
// A music read with cycle_now less than TICK_DIVIDER past the last tick returns
// the held sample. One that advances the phases runs a sequencer: reciprocal
// quotient, remainder, correction, then one phase multiply-add and one sample
// memory read per voice in three-voice mode, or for voice 0 alone in digital
// mode, and a final step that forms the sample.
// A two-word output queue parts req from rsp: when rsp stalls, req keeps taking
// words until the queue is full.
// After arst_n the sample memory is swept to zero with req.ready low; APB writes
// are taken throughout.
module three_voice_wavetable_fetcher_top
	import twf_pkg::*;
#(
	parameter int SAMPLE_ADDR_W = SAMPLE_ADDR_W_DEF,
	parameter int TICK_DIVIDER  = TICK_DIVIDER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	twf_req_if.sink     req,
	twf_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RW = (TICK_DIVIDER > 1) ? $clog2(2 * TICK_DIVIDER) : 1;
	localparam logic [31:0] TICK_D32 = 32'(TICK_DIVIDER);
	localparam logic [RW-1:0] TICK_DR = RW'(TICK_DIVIDER);
	// floor(2**32 / divider), one short for a divider of one
	localparam logic [31:0] TICK_RECIP = (TICK_DIVIDER == 1) ? 32'hFFFF_FFFF :
		32'((64'd1 << 32) / TICK_DIVIDER);
	localparam logic [1:0] VOICE_LAST = 2'(NUM_VOICES - 1);

	// configuration registers
	logic        plus_q;
	logic [11:0] base_a_q;
	logic [11:0] base_b_q;
	logic [11:0] base_c_q;

	// architectural state
	logic [31:0] cnt_q   [NUM_VOICES];
	logic [31:0] step_q  [NUM_VOICES];
	logic [4:0]  shift_q [NUM_VOICES];
	logic [31:0] last_q;
	logic [7:0]  held_q;
	logic [15:0] wp_q;
	logic        digital_q;

	// sequencer
	ms_state_t   state_q;
	ms_state_t   state_d;
	logic [1:0]  seq_v_q;
	logic        rd_pend_q;
	logic [31:0] elapsed_q;
	logic [31:0] now_q;
	logic [31:0] quot_q;
	logic [RW-1:0] rem_q;
	logic [31:0] ticks_q;
	logic [7:0]  sum_q;
	logic        nib_sel_q;

	// output queue
	logic [31:0] fifo_q [2];
	logic        fifo_wp_q;
	logic        fifo_rp_q;
	logic [1:0]  fifo_cnt_q;
	logic        push;
	logic [31:0] push_data;
	logic        pop;

	logic        acc;
	logic        cfg_wr;
	logic        clearing;
	logic        voice_ok;
	cmd_t        cmd;
	logic [1:0]  vsel;
	logic [31:0] cnt_sel;
	logic [31:0] step_sel;
	logic [4:0]  shift_sel;
	logic [11:0] base_sel;
	logic [15:0] ptr_mask;
	logic [15:0] wp_eff;
	logic [31:0] imm_result;
	logic [63:0] quot_prod;
	logic [31:0] rem_prod;
	logic [31:0] rem_full;
	logic        rem_over;
	logic [RW-1:0] rem_fix;
	logic [31:0] adv_prod;
	logic [4:0]  rd_shift;
	logic [4:0]  nib_bit;
	logic [31:0] rd_addr32;
	logic        mem_wr_en;
	logic        mem_rd_en;
	logic [7:0]  mem_rd_data;
	logic [7:0]  sample_d;

	// APB port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plus_q   <= 1'b0;
			base_a_q <= '0;
			base_b_q <= '0;
			base_c_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[3:2]))
				REG_PLUS:   plus_q   <= pwdata[0];
				REG_BASE_A: base_a_q <= pwdata[11:0];
				REG_BASE_B: base_b_q <= pwdata[11:0];
				REG_BASE_C: base_c_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[3:2]))
			REG_PLUS:   prdata = {31'd0, plus_q};
			REG_BASE_A: prdata = {20'd0, base_a_q};
			REG_BASE_B: prdata = {20'd0, base_b_q};
			REG_BASE_C: prdata = {20'd0, base_c_q};
			default:    prdata = '0;
		endcase
	end

	// input handshake
	assign req.ready = (state_q == MS_IDLE) && !clearing && (fifo_cnt_q != 2'd2);
	assign acc       = req.valid & req.ready;
	assign cmd       = cmd_t'(req.cmd);
	assign voice_ok  = req.voice < 2'(NUM_VOICES);

	// one voice port: host voice while idle, sequencer voice otherwise
	assign vsel = (state_q == MS_IDLE) ? req.voice : seq_v_q;

	always_comb begin
		case (vsel)
			2'd0: begin
				cnt_sel   = cnt_q[0];
				step_sel  = step_q[0];
				shift_sel = shift_q[0];
				base_sel  = base_a_q;
			end
			2'd1: begin
				cnt_sel   = cnt_q[1];
				step_sel  = step_q[1];
				shift_sel = shift_q[1];
				base_sel  = base_b_q;
			end
			2'd2: begin
				cnt_sel   = cnt_q[2];
				step_sel  = step_q[2];
				shift_sel = shift_q[2];
				base_sel  = base_c_q;
			end
			default: begin
				cnt_sel   = '0;
				step_sel  = '0;
				shift_sel = '0;
				base_sel  = '0;
			end
		endcase
	end

	// write pointer
	assign ptr_mask = plus_q ? PTR_MASK_PLUS : PTR_MASK_STD;
	assign wp_eff   = wp_q & ptr_mask;

	// result of commands other than music read
	assign imm_result = (cmd == CMD_READ_CNT && voice_ok) ? cnt_sel : 32'd0;

	// tick count: reciprocal estimate, remainder, one correction
	assign quot_prod = 64'(elapsed_q) * 64'(TICK_RECIP);
	assign rem_prod  = quot_q * TICK_D32;
	assign rem_full  = elapsed_q - rem_prod;
	assign rem_over  = rem_q >= TICK_DR;
	assign rem_fix   = rem_over ? rem_q - TICK_DR : rem_q;

	// phase advance, wraps at 32 bits
	assign adv_prod = step_sel * ticks_q;

	// sample address for the current voice
	assign rd_shift  = digital_q ? (plus_q ? DIG_SHIFT_PLUS : DIG_SHIFT_STD) : shift_sel;
	assign nib_bit   = plus_q ? NIB_BIT_PLUS : NIB_BIT_STD;
	assign rd_addr32 = {20'd0, base_sel} + (cnt_sel >> rd_shift);

	assign mem_wr_en = acc && (cmd == CMD_WRITE_BYTE);

	// final sample from the last read
	assign sample_d = digital_q ?
		{4'd0, (nib_sel_q ? mem_rd_data[3:0] : mem_rd_data[7:4])} :
		sum_q + mem_rd_data;

	// sequencer next state and outputs
	always_comb begin
		state_d   = state_q;
		push      = 1'b0;
		push_data = '0;
		mem_rd_en = 1'b0;
		case (state_q)
			MS_IDLE: begin
				if (acc) begin
					if (cmd == CMD_MUSIC_READ) begin
						state_d = MS_QUOT;
					end else begin
						push      = 1'b1;
						push_data = imm_result;
					end
				end
			end
			MS_QUOT: begin
				if (elapsed_q < TICK_D32) begin
					push      = 1'b1;
					push_data = {24'd0, held_q};
					state_d   = MS_IDLE;
				end else begin
					state_d = MS_REM;
				end
			end
			MS_REM: state_d = MS_FIX;
			MS_FIX: state_d = MS_ADV;
			MS_ADV: begin
				if (digital_q || seq_v_q == VOICE_LAST) begin
					state_d = MS_READ;
				end
			end
			MS_READ: begin
				mem_rd_en = 1'b1;
				if (digital_q || seq_v_q == VOICE_LAST) begin
					state_d = MS_SUM;
				end
			end
			MS_SUM: begin
				push      = 1'b1;
				push_data = {24'd0, sample_d};
				state_d   = MS_IDLE;
			end
			default: state_d = MS_IDLE;
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= MS_IDLE;
			seq_v_q   <= '0;
			rd_pend_q <= 1'b0;
			for (int v = 0; v < NUM_VOICES; v++) begin
				cnt_q[v]   <= '0;
				step_q[v]  <= '0;
				shift_q[v] <= SIZE_SHIFT_RST;
			end
			last_q    <= '0;
			held_q    <= '0;
			wp_q      <= '0;
			digital_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				MS_IDLE: begin
					if (acc) begin
						case (cmd)
							CMD_SET_NOTE: begin
								if (voice_ok) step_q[vsel] <= req.value;
							end
							CMD_RESET_CNT: begin
								if (voice_ok) cnt_q[vsel] <= '0;
							end
							CMD_SET_SIZE: begin
								if (voice_ok) shift_q[vsel] <= req.value[4:0];
							end
							CMD_PTR_BYTE: wp_q <= {wp_q[7:0], req.value[7:0]} & ptr_mask;
							CMD_WRITE_BYTE: wp_q <= (wp_eff + 16'd1) & ptr_mask;
							CMD_SET_MODE: digital_q <= (req.value[7:4] == 4'd0);
							default: ;
						endcase
					end
				end
				MS_FIX: begin
					last_q    <= now_q - 32'(rem_fix);
					seq_v_q   <= '0;
					rd_pend_q <= 1'b0;
				end
				MS_ADV: begin
					cnt_q[vsel] <= cnt_sel + adv_prod;
					if (digital_q || seq_v_q == VOICE_LAST) begin
						seq_v_q <= '0;
					end else begin
						seq_v_q <= seq_v_q + 2'd1;
					end
				end
				MS_READ: begin
					rd_pend_q <= 1'b1;
					seq_v_q   <= seq_v_q + 2'd1;
				end
				MS_SUM: held_q <= sample_d;
				default: ;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			MS_IDLE: begin
				elapsed_q <= req.cycle_now - last_q;
				now_q     <= req.cycle_now;
			end
			MS_QUOT: quot_q <= quot_prod[63:32];
			MS_REM:  rem_q <= rem_full[RW-1:0];
			MS_FIX: begin
				ticks_q <= quot_q + {31'd0, rem_over};
				sum_q   <= '0;
			end
			MS_READ: begin
				nib_sel_q <= cnt_sel[nib_bit];
				if (rd_pend_q) begin
					sum_q <= sum_q + mem_rd_data;
				end
			end
			default: ;
		endcase
	end

	// sample memory
	twf_sample_ram #(
		.ADDR_W (SAMPLE_ADDR_W)
	) u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (mem_wr_en),
		.wr_addr  (wp_eff[SAMPLE_ADDR_W-1:0]),
		.wr_data  (req.value[7:0]),
		.rd_en    (mem_rd_en),
		.rd_addr  (rd_addr32[SAMPLE_ADDR_W-1:0]),
		.rd_data  (mem_rd_data),
		.clearing (clearing)
	);

	// two-word output queue
	assign pop              = rsp.valid & rsp.ready;
	assign rsp.valid        = fifo_cnt_q != 2'd0;
	assign rsp.result_value = fifo_q[fifo_rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fifo_wp_q  <= 1'b0;
			fifo_rp_q  <= 1'b0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) fifo_wp_q <= ~fifo_wp_q;
			if (pop)  fifo_rp_q <= ~fifo_rp_q;
			if (push && !pop) begin
				fifo_cnt_q <= fifo_cnt_q + 2'd1;
			end else if (pop && !push) begin
				fifo_cnt_q <= fifo_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[fifo_wp_q] <= push_data;
		end
	end

endmodule
